FILE: hdl/sda_pkg.sv
// Shared types, codes and constants for the scaled decimal ALU.
package sda_pkg;

  localparam int MAX_SCALE_DEF = 18;
  localparam int MUL_RETRIES = 36;
  localparam logic [4:0] KEEP_RESET = 5'd8;
  localparam logic [4:0] EXTRA_RESET = 5'd8;

  typedef enum logic [2:0] {
    ACT_ADD  = 3'd0,
    ACT_SUB  = 3'd1,
    ACT_MUL  = 3'd2,
    ACT_DIV  = 3'd3,
    ACT_CMP  = 3'd4,
    ACT_ABS  = 3'd5,
    ACT_NEG  = 3'd6,
    ACT_ZERO = 3'd7
  } action_t;

  localparam logic CFG_KEEP = 1'b0;
  localparam logic CFG_EXTRA = 1'b1;

  // Request to and answer from the shared divide-by-signal unit.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [63:0] rem;
  } div_rsp_t;

endpackage

FILE: hdl/sda_div.sv
// Restoring radix-2 signed divider, one quotient bit per cycle.
module sda_div
  import sda_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] dvd;
  logic [63:0] dvs;
  logic [64:0] rem;
  logic [6:0]  cnt;
  logic        busy;
  logic        qneg;
  logic        rneg;
  logic [64:0] trial;
  logic [64:0] shifted;

  always_comb begin
    shifted = {rem[63:0], dvd[63]};
    trial = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    rsp.done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= 7'd64;
      dvd <= req.num[63] ? 64'd0 - req.num : req.num;
      dvs <= req.den[63] ? 64'd0 - req.den : req.den;
      qneg <= req.num[63] ^ req.den[63];
      rneg <= req.num[63];
      rem <= '0;
    end else if (busy) begin
      if (cnt == 7'd0) begin
        busy <= 1'b0;
        rsp.done <= 1'b1;
        rsp.quo <= qneg ? 64'd0 - dvd : dvd;
        rsp.rem <= rneg ? 64'd0 - rem[63:0] : rem[63:0];
      end else begin
        cnt <= cnt - 7'd1;
        if (!trial[64]) begin
          rem <= trial;
          dvd <= {dvd[62:0], 1'b1};
        end else begin
          rem <= shifted;
          dvd <= {dvd[62:0], 1'b0};
        end
      end
    end
  end

endmodule

FILE: hdl/scaled_decimal_alu.sv
// Scaled decimal ALU: top level with the sequencer around a shared divider.
//
// Usage: an operation request arrives on s_axis (tuser = action, tdata =
// operands); one result leaves on m_axis per request. cfg_we/cfg_idx/cfg_data
// write mul_keep_scale (index 0) and div_extra_digits (index 1); the user
// must write them only while idle, and the block itself does not enforce it.
// The block takes one request at a time: s_axis_tready is high only when no
// request is in work and the output register is empty.
// Latency depends on the action. Abs, neg and is_zero go straight from
// dispatch to the output register. Every division by ten runs on a small
// divide-by-ten unit, eight quotient bits per cycle; the final divide runs
// on a radix-2 divider. Each multiply overflow test is one 64x64 step split
// into 32-bit partial products. Add/sub/cmp take up to 18 divide-by-ten
// passes; mul up to 36 retries plus up to 18 strips; div up to 19 overflow
// steps and one division. The longest request is a multiply that retries to
// the limit and then strips.
// Reset (rst, synchronous) returns the sequencer to idle, empties the output
// register and sets both configuration registers to 8.
// When the receiver stalls, the result holds in the output register and no
// new request is taken until it is delivered.
module scaled_decimal_alu
  import sda_pkg::*;
#(
  parameter int MAX_SCALE = MAX_SCALE_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_mantissa[63:0], a_scale[68:64], b_mantissa[132:69], b_scale[137:133], zero fill
  input  logic [143:0] s_axis_tdata,
  // action[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // r_mantissa[63:0], r_scale[68:64], order[70:69], zero_flag[71]
  output logic [71:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic         cfg_idx,
  input  logic [4:0]   cfg_data
);

  localparam logic [4:0] MAXS = 5'(MAX_SCALE);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_AL_POW, S_AL_OVF, S_AL_STRIP, S_AL_STRIPW, S_AL_FIN, S_AL_WRAP, S_AL_OP,
    S_MU_CHK, S_MU_DROP, S_MU_DROPW, S_MU_STRIP, S_MU_STRIPW,
    S_DV_POW, S_DV_CHK, S_DV_DIV, S_DV_DIVW,
    S_OVF, S_OUT
  } state_t;

  state_t state, ret;
  logic [4:0] keep, extra;
  logic [2:0] act;
  logic signed [63:0] am, bm, rm, hm, lm;
  logic [4:0] as_, bs, rs, hs, diff, ext;
  logic       a_lo;
  logic [5:0] retries;
  logic signed [1:0] ord;
  logic       zf;

  // power of ten tracker
  logic [63:0] pw;
  logic [4:0]  pcnt;

  // overflow unit: x*y, four 32x32 partial products, one per cycle
  logic signed [63:0] ox, oy;
  logic [63:0] ux, uy;
  logic [127:0] acc;
  logic [1:0]  ostep;
  logic        ovf;
  logic [31:0] pa, pb;
  logic [63:0] pp;

  div_req_t dreq;
  div_rsp_t drsp;

  sda_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // divide-by-ten unit: eight quotient bits per cycle, 4-bit remainder
  logic        d10_go;
  logic [63:0] d10_num;
  logic        d10_busy, d10_done, d10_neg;
  logic [2:0]  d10_cnt;
  logic [63:0] d10_q, d10_q_next;
  logic [3:0]  d10_r, d10_r_next;
  logic [63:0] d10_quo;
  logic        d10_zero;

  always_comb begin
    logic [4:0] t5;
    d10_q_next = d10_q;
    d10_r_next = d10_r;
    for (int i = 0; i < 8; i++) begin
      t5 = {d10_r_next, d10_q_next[63]};
      d10_q_next = {d10_q_next[62:0], (t5 >= 5'd10)};
      d10_r_next = (t5 >= 5'd10) ? 4'(t5 - 5'd10) : t5[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d10_busy <= 1'b0;
      d10_done <= 1'b0;
    end else if (d10_go) begin
      d10_busy <= 1'b1;
      d10_done <= 1'b0;
      d10_cnt <= '0;
      d10_neg <= d10_num[63];
      d10_q <= d10_num[63] ? 64'd0 - d10_num : d10_num;
      d10_r <= '0;
    end else if (d10_busy) begin
      d10_q <= d10_q_next;
      d10_r <= d10_r_next;
      d10_cnt <= d10_cnt + 3'd1;
      if (d10_cnt == 3'd7) begin
        d10_busy <= 1'b0;
        d10_done <= 1'b1;
      end
    end else begin
      d10_done <= 1'b0;
    end
  end

  // truncate toward zero: apply the dividend sign to the magnitude quotient
  assign d10_quo = d10_neg ? 64'd0 - d10_q : d10_q;
  assign d10_zero = (d10_r == 4'd0);

  logic [4:0] in_as, in_bs;
  assign in_as = (s_axis_tdata[68:64] > MAXS) ? MAXS : s_axis_tdata[68:64];
  assign in_bs = (s_axis_tdata[137:133] > MAXS) ? MAXS : s_axis_tdata[137:133];

  logic [5:0] mul_sum;
  assign mul_sum = {1'b0, as_} + {1'b0, bs};

  logic [4:0] ext_cap;
  logic       div_short;
  assign ext_cap = (extra > MAXS) ? MAXS : extra;
  // negative result scale: drop the extra digits entirely
  assign div_short = ({1'b0, as_} + {1'b0, ext_cap}) < {1'b0, bs};

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  always_comb begin
    unique case (ostep)
      2'd0: begin pa = ux[31:0];  pb = uy[31:0];  end
      2'd1: begin pa = ux[63:32]; pb = uy[31:0];  end
      2'd2: begin pa = ux[31:0];  pb = uy[63:32]; end
      default: begin pa = ux[63:32]; pb = uy[63:32]; end
    endcase
    pp = pa * pb;
  end

  logic [127:0] acc_next;
  always_comb begin
    unique case (ostep)
      2'd0: acc_next = {64'd0, pp};
      2'd1, 2'd2: acc_next = acc + {32'd0, pp, 32'd0};
      default: acc_next = acc + {pp, 64'd0};
    endcase
  end

  // overflow verdict from full magnitude product
  logic ovf_now;
  always_comb begin
    if (ux == 64'd0 || uy == 64'd0) ovf_now = 1'b0;
    else if (ox[63] != oy[63]) ovf_now = acc_next > 128'h8000000000000000;
    else ovf_now = acc_next > 128'h7fffffffffffffff;
  end

  // wrapped signed product from the finished magnitude product
  logic signed [63:0] wprod;
  assign wprod = (ox[63] ^ oy[63]) ? 64'd0 - acc[63:0] : acc[63:0];

  logic [63:0] absa, absb;
  assign absa = am[63] ? 64'd0 - am : am;
  assign absb = bm[63] ? 64'd0 - bm : bm;

  always_ff @(posedge clk) begin
    dreq.start <= 1'b0;
    d10_go <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      keep <= KEEP_RESET;
      extra <= EXTRA_RESET;
      ostep <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_KEEP) keep <= cfg_data;
        else extra <= cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          act <= s_axis_tuser;
          am <= s_axis_tdata[63:0];
          as_ <= in_as;
          bm <= s_axis_tdata[132:69];
          bs <= in_bs;
          rm <= '0; rs <= '0; ord <= '0; zf <= 1'b0;
          state <= S_DISPATCH;
        end
        S_DISPATCH: begin
          unique case (action_t'(act))
            ACT_ADD, ACT_SUB, ACT_CMP: begin
              if (as_ == bs) state <= S_AL_OP;
              else begin
                a_lo <= as_ < bs;
                lm <= (as_ < bs) ? am : bm;
                hm <= (as_ < bs) ? bm : am;
                hs <= (as_ < bs) ? bs : as_;
                diff <= (as_ < bs) ? bs - as_ : as_ - bs;
                pw <= 64'd1; pcnt <= '0;
                state <= S_AL_POW;
              end
            end
            ACT_MUL: begin
              rs <= (mul_sum > {1'b0, MAXS}) ? MAXS : mul_sum[4:0];
              retries <= '0;
              if (am == 0 || bm == 0) begin
                rm <= '0; state <= S_MU_STRIP;
              end else begin
                ox <= am; oy <= bm; ux <= absa; uy <= absb;
                ostep <= '0; ret <= S_MU_CHK; state <= S_OVF;
              end
            end
            ACT_DIV: begin
              if (bm == 0) state <= S_OUT;
              else begin
                ext <= div_short ? 5'd0 : ext_cap;
                pw <= 64'd1; pcnt <= '0;
                state <= S_DV_POW;
              end
            end
            ACT_ABS: begin rs <= as_; rm <= am[63] ? 64'd0 - am : am; state <= S_OUT; end
            ACT_NEG: begin rs <= as_; rm <= 64'd0 - am; state <= S_OUT; end
            default: begin zf <= (am == 0); state <= S_OUT; end
          endcase
        end
        // build 10^diff one multiply by ten per cycle
        S_AL_POW: begin
          if (pcnt == diff) begin
            ox <= lm; oy <= pw; ux <= lm[63] ? 64'd0 - lm : lm; uy <= pw;
            ostep <= '0; ret <= S_AL_OVF; state <= S_OVF;
          end else begin
            pw <= pw * 64'd10; pcnt <= pcnt + 5'd1;
          end
        end
        S_AL_OVF: begin
          if (ovf) state <= S_AL_STRIP;
          else begin lm <= wprod; state <= S_AL_FIN; end
        end
        S_AL_STRIP: begin
          if (diff == 0) begin
            pw <= 64'd1; pcnt <= '0; state <= S_AL_FIN;
          end else begin
            d10_num <= hm; d10_go <= 1'b1;
            state <= S_AL_STRIPW;
          end
        end
        S_AL_STRIPW: if (d10_done) begin
          if (d10_zero) begin
            hm <= d10_quo; hs <= hs - 5'd1; diff <= diff - 5'd1;
            state <= S_AL_STRIP;
          end else begin
            pw <= 64'd1; pcnt <= '0; state <= S_AL_FIN;
          end
        end
        S_AL_FIN: begin
          // write back if no overflow; after a strip rebuild 10^diff, wrap multiply
          if (!ovf) begin
            if (a_lo) begin am <= lm; bm <= hm; end
            else begin bm <= lm; am <= hm; end
            as_ <= hs; bs <= hs;
            state <= S_AL_OP;
          end else if (pcnt == diff) begin
            ox <= lm; oy <= pw; ux <= lm[63] ? 64'd0 - lm : lm; uy <= pw;
            ostep <= '0; ret <= S_AL_WRAP; state <= S_OVF;
          end else begin
            pw <= pw * 64'd10; pcnt <= pcnt + 5'd1;
          end
        end
        // take the wrapped product whatever the overflow verdict
        S_AL_WRAP: begin
          lm <= wprod; ovf <= 1'b0; state <= S_AL_FIN;
        end
        S_AL_OP: begin
          if (action_t'(act) == ACT_ADD) begin rs <= as_; rm <= am + bm; end
          else if (action_t'(act) == ACT_SUB) begin rs <= as_; rm <= am - bm; end
          else ord <= (am < bm) ? -2'sd1 : ((am > bm) ? 2'sd1 : 2'sd0);
          state <= S_OUT;
        end
        S_MU_CHK: begin
          rm <= wprod;
          if (!ovf || retries == 6'(MUL_RETRIES)) state <= S_MU_STRIP;
          else state <= S_MU_DROP;
        end
        S_MU_DROP: begin
          d10_go <= 1'b1;
          if ((as_ > 0 && rs > 0) || !(bs > 0 && rs > 0) && absa > absb)
            d10_num <= am;
          else d10_num <= bm;
          state <= S_MU_DROPW;
        end
        S_MU_DROPW: if (d10_done) begin
          if (as_ > 0 && rs > 0) begin
            am <= d10_quo; as_ <= as_ - 5'd1; rs <= rs - 5'd1;
            ox <= d10_quo; ux <= d10_quo[63] ? 64'd0 - d10_quo : d10_quo;
            oy <= bm; uy <= absb;
          end else if (bs > 0 && rs > 0) begin
            bm <= d10_quo; bs <= bs - 5'd1; rs <= rs - 5'd1;
            oy <= d10_quo; uy <= d10_quo[63] ? 64'd0 - d10_quo : d10_quo;
            ox <= am; ux <= absa;
          end else if (absa > absb) begin
            am <= d10_quo;
            ox <= d10_quo; ux <= d10_quo[63] ? 64'd0 - d10_quo : d10_quo;
            oy <= bm; uy <= absb;
          end else begin
            bm <= d10_quo;
            oy <= d10_quo; uy <= d10_quo[63] ? 64'd0 - d10_quo : d10_quo;
            ox <= am; ux <= absa;
          end
          retries <= retries + 6'd1;
          ostep <= '0; ret <= S_MU_CHK; state <= S_OVF;
        end
        S_MU_STRIP: begin
          if (rs > keep) begin
            d10_num <= rm; d10_go <= 1'b1;
            state <= S_MU_STRIPW;
          end else state <= S_OUT;
        end
        S_MU_STRIPW: if (d10_done) begin
          if (d10_zero) begin
            rm <= d10_quo; rs <= rs - 5'd1; state <= S_MU_STRIP;
          end else state <= S_OUT;
        end
        S_DV_POW: begin
          if (pcnt == ext) begin
            ox <= am; oy <= pw; ux <= absa; uy <= pw;
            ostep <= '0; ret <= S_DV_CHK; state <= S_OVF;
          end else begin
            pw <= pw * 64'd10; pcnt <= pcnt + 5'd1;
          end
        end
        S_DV_CHK: begin
          if (!ovf || ext == 0) begin
            lm <= wprod; state <= S_DV_DIV;
          end else begin
            ext <= ext - 5'd1; pw <= 64'd1; pcnt <= '0; state <= S_DV_POW;
          end
        end
        S_DV_DIV: begin
          begin
            logic signed [6:0] t;
            t = $signed({2'b0, as_}) + $signed({2'b0, ext}) - $signed({2'b0, bs});
            if (t < 0) rs <= '0;
            else if (t > $signed({2'b0, MAXS})) rs <= MAXS;
            else rs <= t[4:0];
          end
          dreq.num <= lm; dreq.den <= bm; dreq.start <= 1'b1;
          state <= S_DV_DIVW;
        end
        S_DV_DIVW: if (drsp.done) begin
          rm <= (bm == -64'sd1) ? 64'd0 - lm : drsp.quo;
          state <= S_OUT;
        end
        S_OVF: begin
          acc <= acc_next;
          if (ostep == 2'd3) begin
            ovf <= ovf_now; state <= ret;
          end
          ostep <= ostep + 2'd1;
        end
        default: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= {(action_t'(act) == ACT_CMP) ? 1'b0 :
                           (action_t'(act) == ACT_ZERO) ? zf : (rm == 0),
                           ord, rs, rm};
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/sda_checker.sv
// Port-level assertions for the scaled decimal ALU, bound to the top level.
module sda_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [71:0]  m_axis_tdata
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  a_no_take_while_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken with result pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready after accept");

  a_order_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[70:69] != 2'b10 && m_axis_tdata[68:64] <= 5'd18)
    else $error("bad result fields");

endmodule

bind scaled_decimal_alu sda_checker u_sda_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

FILE: dv/tb.sv
// Testbench for scaled_decimal_alu: directed table, then random requests checked by a predictor.
module tb;
  import sda_pkg::*;

  typedef struct {
    longint     mant;
    logic [4:0] scl;
    logic [1:0] ord;
    logic       zf;
  } dec_result_t;

  typedef struct {
    action_t     act;
    longint      am;
    int          asc;
    longint      bm;
    int          bsc;
    bit          typed;
    dec_result_t res;
  } vector_t;

  localparam longint MAXV = 64'sh7fffffffffffffff;
  localparam longint MINV = 64'sh8000000000000000;
  localparam logic [1:0] ORD_LT = 2'b11;
  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // a_mantissa, a_scale, b_mantissa, b_scale, zero fill
  logic [143:0] s_axis_tdata = '0;
  // action
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // r_mantissa, r_scale, order, zero_flag
  logic [71:0]  m_axis_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_idx = CFG_KEEP;
  logic [4:0]   cfg_data = '0;

  int keep_scale = 8;
  int extra_digits = 8;
  dec_result_t pending_results[$];
  int errors = 0;
  bit calm = 1'b0;
  int stall_left = 0;

  scaled_decimal_alu uut (.*);

  always #6 clk = ~clk;

  initial begin
    #500_000_000;
    $display("scaled_decimal_alu: mismatch");
    $finish;
  end

  function automatic longint pow10(int n);
    longint p = 1;
    if (n > 18) n = 18;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  // Wrapped product in p; true when the exact product leaves 64 bits.
  function automatic bit mul_wraps(input longint x, input longint y, output longint p);
    logic [63:0] ux, uy, lim;
    p = x * y;
    ux = 64'(x < 0 ? -x : x);
    uy = 64'(y < 0 ? -y : y);
    if (ux == 0 || uy == 0) return 1'b0;
    lim = ((x < 0) != (y < 0)) ? 64'h8000000000000000 : 64'h7fffffffffffffff;
    return ux > lim / uy;
  endfunction

  // Bring the lower-scale operand up to the other's scale, stripping zeros on overflow.
  function automatic void align_up(inout longint lm, inout int ls,
                                   inout longint hm, inout int hs);
    int diff;
    longint r;
    diff = hs - ls;
    if (diff > 18) diff = 18;
    if (mul_wraps(lm, pow10(diff), r)) begin
      while (diff > 0 && hm % 10 == 0) begin
        hm = hm / 10;
        hs--;
        diff--;
      end
      void'(mul_wraps(lm, pow10(diff), r));
    end
    lm = r;
    ls = hs;
  endfunction

  function automatic dec_result_t decimal_result(action_t act, longint am, int asc,
                                                 longint bm, int bsc);
    dec_result_t res;
    longint rm, num;
    int rs, extra, tries;
    res = '{0, 0, ORD_EQ, 1'b0};
    if (asc > 18) asc = 18;
    if (bsc > 18) bsc = 18;
    rm = 0;
    rs = 0;
    case (act)
      ACT_ADD, ACT_SUB, ACT_CMP: begin
        if (asc < bsc) align_up(am, asc, bm, bsc);
        else if (asc > bsc) align_up(bm, bsc, am, asc);
        rs = asc;
        rm = (act == ACT_SUB) ? am - bm : am + bm;
        if (act == ACT_CMP) begin
          res.ord = am < bm ? ORD_LT : (am > bm ? ORD_GT : ORD_EQ);
          rm = 0;
          rs = 0;
        end
      end
      ACT_MUL: begin
        rs = asc + bsc;
        if (rs > 18) rs = 18;
        tries = 0;
        if (am != 0 && bm != 0 && mul_wraps(am, bm, rm)) begin
          while (tries < MUL_RETRIES) begin
            if (asc > 0 && rs > 0) begin
              am = am / 10; asc--; rs--;
            end else if (bsc > 0 && rs > 0) begin
              bm = bm / 10; bsc--; rs--;
            end else if ($unsigned(am < 0 ? -am : am) > $unsigned(bm < 0 ? -bm : bm)) begin
              am = am / 10;
            end else begin
              bm = bm / 10;
            end
            if (!mul_wraps(am, bm, rm)) break;
            tries++;
          end
        end
        while (rs > keep_scale && rm % 10 == 0) begin
          rm = rm / 10;
          rs--;
        end
      end
      ACT_DIV: begin
        if (bm != 0) begin
          extra = extra_digits > 18 ? 18 : extra_digits;
          rs = asc + extra - bsc;
          if (rs < 0) begin
            extra = 0;
            rs = 0;
          end
          if (rs > 18) rs = 18;
          if (mul_wraps(am, pow10(extra), num)) begin
            while (extra > 0) begin
              extra--;
              rs = asc + extra - bsc;
              if (rs < 0) rs = 0;
              if (!mul_wraps(am, pow10(extra), num)) break;
            end
            if (rs > 18) rs = 18;
          end
          rm = (bm == -1) ? -num : num / bm;
        end
      end
      ACT_ABS: begin
        rs = asc;
        rm = am < 0 ? -am : am;
      end
      ACT_NEG: begin
        rs = asc;
        rm = -am;
      end
      default: ;
    endcase
    res.mant = rm;
    res.scl = rs[4:0];
    if (act == ACT_ZERO) res.zf = (am == 0);
    else if (act != ACT_CMP) res.zf = (rm == 0);
    return res;
  endfunction

  task automatic write_cfg(int keep, int extra);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_KEEP;
    cfg_data <= keep[4:0];
    @(posedge clk);
    cfg_idx <= CFG_EXTRA;
    cfg_data <= extra[4:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    keep_scale = keep;
    extra_digits = extra;
    @(posedge clk);
  endtask

  // Called at a rising edge; returns once the request is taken and any random idle gap is over.
  task automatic send_request(vector_t v);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= v.act;
    s_axis_tdata <= {6'b0, 5'(v.bsc), v.bm, 5'(v.asc), v.am};
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    pending_results.push_back(v.typed ? v.res :
                              decimal_result(v.act, v.am, v.asc, v.bm, v.bsc));
    gap = 0;
    if ($urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic longint random_mantissa();
    longint m;
    case ($urandom_range(0, 6))
      0: m = longint'($urandom_range(0, 2000)) - 1000;
      1: m = {$urandom, $urandom};
      2: m = (longint'($urandom_range(0, 99)) - 50) * pow10($urandom_range(1, 17));
      3: m = $urandom_range(0, 1) ? MAXV - $urandom_range(0, 3) : MINV + $urandom_range(0, 3);
      4: m = longint'($signed($urandom)) * $urandom_range(1, 1000);
      5: m = {$urandom, $urandom} >>> $urandom_range(1, 62);
      default: m = $urandom_range(0, 3) - 1;
    endcase
    return m;
  endfunction

  function automatic int random_scale();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(19, 31) : $urandom_range(0, 18);
  endfunction

  task automatic drain();
    while (pending_results.size() > 0) @(posedge clk);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver side: random stalls, with calm stretches that start no new stall.
  always @(posedge clk) begin
    if ($urandom_range(0, 499) == 0) calm <= ~calm;
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                   : $urandom_range(1, 3);
    end
  end

  // Sample between edges; the handshake completes at the following rising edge.
  always @(negedge clk) begin
    dec_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[63:0] != want.mant) begin
          $error("r_mantissa expected %0d actual %0d", want.mant,
                 $signed(m_axis_tdata[63:0]));
          errors++;
        end
        if (m_axis_tdata[68:64] != want.scl) begin
          $error("r_scale expected %0d actual %0d", want.scl, m_axis_tdata[68:64]);
          errors++;
        end
        if (m_axis_tdata[70:69] != want.ord) begin
          $error("order expected %b actual %b", want.ord, m_axis_tdata[70:69]);
          errors++;
        end
        if (m_axis_tdata[71] != want.zf) begin
          $error("zero_flag expected %b actual %b", want.zf, m_axis_tdata[71]);
          errors++;
        end
      end
    end
  end

  initial begin
    vector_t directed[$];
    vector_t v;
    int keeps[6];
    int extras[6];
    int wait_cnt;
    directed = '{
      '{ACT_ADD, 0, 0, 0, 0, 1, '{0, 0, ORD_EQ, 1}},
      '{ACT_ADD, MAXV, 0, 1, 0, 1, '{MINV, 0, ORD_EQ, 0}},
      '{ACT_SUB, MINV, 0, 1, 0, 1, '{MAXV, 0, ORD_EQ, 0}},
      '{ACT_ADD, 1, 0, 1, 18, 0, '{0, 0, ORD_EQ, 0}},
      '{ACT_ADD, 5, 31, 1, 0, 0, '{0, 0, ORD_EQ, 0}},
      '{ACT_ADD, MAXV, 0, 100, 2, 0, '{0, 0, ORD_EQ, 0}},
      '{ACT_CMP, 1, 0, 10, 1, 1, '{0, 0, ORD_EQ, 0}},
      '{ACT_CMP, -1, 0, 1, 0, 1, '{0, 0, ORD_LT, 0}},
      '{ACT_CMP, MAXV, 0, MINV, 18, 0, '{0, 0, ORD_EQ, 0}},
      '{ACT_SUB, 3, 2, MAXV, 0, 0, '{0, 0, ORD_EQ, 0}},
      '{ACT_MUL, 0, 5, 7, 9, 0, '{0, 0, ORD_EQ, 0}},
      '{ACT_MUL, MAXV, 9, MAXV, 9, 0, '{0, 0, ORD_EQ, 0}},
      '{ACT_MUL, MINV, 0, MINV, 0, 0, '{0, 0, ORD_EQ, 0}},
      '{ACT_MUL, 25, 1, 4, 1, 0, '{0, 0, ORD_EQ, 0}},
      '{ACT_DIV, 7, 0, 0, 0, 1, '{0, 0, ORD_EQ, 1}},
      '{ACT_DIV, MINV, 0, -1, 0, 0, '{0, 0, ORD_EQ, 0}},
      '{ACT_DIV, 10, 0, 3, 0, 0, '{0, 0, ORD_EQ, 0}},
      '{ACT_DIV, MAXV, 0, 7, 31, 0, '{0, 0, ORD_EQ, 0}},
      '{ACT_ABS, MINV, 3, 0, 0, 1, '{MINV, 3, ORD_EQ, 0}},
      '{ACT_NEG, MINV, 3, 0, 0, 1, '{MINV, 3, ORD_EQ, 0}},
      '{ACT_NEG, 5, 31, 0, 0, 1, '{-5, 18, ORD_EQ, 0}},
      '{ACT_ABS, -42, 2, 0, 0, 1, '{42, 2, ORD_EQ, 0}},
      '{ACT_ZERO, 0, 4, 0, 0, 1, '{0, 0, ORD_EQ, 1}},
      '{ACT_ZERO, -1, 4, -1, 31, 1, '{0, 0, ORD_EQ, 0}}
    };
    keeps = '{8, 0, 18, 31, 0, 5};
    extras = '{8, 0, 18, 31, 0, 19};
    keeps[4] = $urandom_range(0, 31);
    extras[4] = $urandom_range(0, 31);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_request(directed[i]);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(keeps[ph], extras[ph]);
      for (int n = 0; n < 305; n++) begin
        v.act = action_t'($urandom_range(0, 7));
        v.am = random_mantissa();
        v.bm = random_mantissa();
        v.asc = random_scale();
        v.bsc = random_scale();
        v.typed = 1'b0;
        send_request(v);
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("scaled_decimal_alu: match");
    end else begin
      $display("scaled_decimal_alu: mismatch");
    end
    $finish;
  end
endmodule
